FILE: hw/rtl/trs_pkg.sv
// package for the supersampling triangle rasterizer
// request codes, default sizes, controller states and the coverage blend
// no dependencies
`timescale 1ns / 1ps

package trs_pkg;

	localparam int FB_WIDTH_DEF  = 64;
	localparam int FB_HEIGHT_DEF = 64;
	localparam int FRAC_BITS_DEF = 4;

	localparam logic [12:0] COUNT_MAX = 13'd8191;

	typedef enum logic [1:0] {
		REQ_DRAW  = 2'd0,
		REQ_READ  = 2'd1,
		REQ_WRITE = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_MUL,
		ST_CHECK,
		ST_WALK,
		ST_DRAIN,
		ST_PIX,
		ST_DONE
	} state_t;

	// per channel (old*(4-n) + new*n) / 4
	function automatic logic [23:0] blend(input logic [23:0] old, input logic [23:0] nw,
		input logic [2:0] n);
		logic [23:0] res;
		logic [9:0]  c;
		res = '0;
		for (int ch = 0; ch < 3; ch++) begin
			c = 10'(old[ch*8 +: 8]) * 10'(3'd4 - n) + 10'(nw[ch*8 +: 8]) * 10'(n);
			res[ch*8 +: 8] = c[9:2];
		end
		return res;
	endfunction

endpackage

FILE: hw/rtl/trs_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module trs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/triangle_raster_supersample.sv
// channel | direction | handshake           | words
// request | in        | start, busy         | req_type, vert0..2 x/y, draw_color, pixel_x/y
// result  | out       | done (one cycle)    | pixel_color, pixels_changed, front_facing
//
// after reset a clearing pass writes zero to every frame store entry, one per cycle,
// with busy high
// read in range: ST_PIX, then ST_DONE; any other request but draw goes straight to ST_DONE
// draw: ST_SETUP, ST_MUL (one shared multiplier, eight products) and ST_CHECK, then one bounding
// box pixel per cycle in ST_WALK, then ST_DRAIN and ST_DONE; or ST_DONE if nothing is walked
// the result is shown for one cycle with done; the receiver cannot stall
// depends on trs_pkg, trs_ram
`timescale 1ns / 1ps

module triangle_raster_supersample #(
	parameter int FB_WIDTH  = trs_pkg::FB_WIDTH_DEF,
	parameter int FB_HEIGHT = trs_pkg::FB_HEIGHT_DEF,
	parameter int FRAC_BITS = trs_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic signed [12:0] vert0_x,
	input  logic signed [12:0] vert0_y,
	input  logic signed [12:0] vert1_x,
	input  logic signed [12:0] vert1_y,
	input  logic signed [12:0] vert2_x,
	input  logic signed [12:0] vert2_y,
	input  logic [23:0]        draw_color,
	input  logic [5:0]         pixel_x,
	input  logic [5:0]         pixel_y,
	output logic               done,
	output logic [23:0]        pixel_color,
	output logic [12:0]        pixels_changed,
	output logic               front_facing
);

	import trs_pkg::*;

	localparam int DEPTH = FB_WIDTH * FB_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int MAXFB = (FB_WIDTH > FB_HEIGHT) ? FB_WIDTH : FB_HEIGHT;
	localparam int PTB   = $clog2((MAXFB * 4 + 4) << FRAC_BITS) + 1;
	localparam int PW    = (PTB > 15) ? PTB : 15;
	localparam int DW    = PW + 1;
	localparam int EW    = 2 * DW + 2;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	function automatic logic signed [13:0] trunc_px(input logic signed [12:0] v);
		logic signed [13:0] w;
		logic signed [13:0] m;
		w = 14'(v);
		if (w < 0) begin
			m = -w;
			return -(m >>> FRAC_BITS);
		end
		return w >>> FRAC_BITS;
	endfunction

	state_t state_q, state_d;

	logic [AW-1:0]  clr_q;
	logic           pv_q;
	logic [2:0]     tag_q;
	logic [3:0]     mul_k_q;
	logic signed [2*DW-1:0] prod_q;

	logic signed [12:0] vx_q [3];
	logic signed [12:0] vy_q [3];
	logic [23:0]        color_q;
	logic signed [DW-1:0] dx_q [3];
	logic signed [DW-1:0] dy_q [3];
	logic signed [13:0] minx_q, maxx_q, miny_q, maxy_q;
	logic signed [13:0] x_q, y_q;
	logic signed [EW-1:0] wind_q;
	logic signed [EW-1:0] erow_q [3];
	logic signed [EW-1:0] ecur_q [3];

	logic [23:0] res_color_q;
	logic [12:0] cnt_q;
	logic        front_q;

	logic          valid_s1;
	logic [AW-1:0] addr_s1;
	logic [2:0]    n_s1;

	logic [23:0] rdata;

	// vertices in sub-sample units
	logic signed [PW-1:0] sx [3];
	logic signed [PW-1:0] sy [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sx[i] = PW'(vx_q[i]) <<< 2;
			sy[i] = PW'(vy_q[i]) <<< 2;
		end
	end

	// bounding box, truncated and clipped
	logic signed [13:0] tx [3];
	logic signed [13:0] ty [3];
	logic signed [13:0] bminx, bmaxx, bminy, bmaxy;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tx[i] = trunc_px(vx_q[i]);
			ty[i] = trunc_px(vy_q[i]);
		end
		bminx = tx[0];
		bmaxx = tx[0];
		bminy = ty[0];
		bmaxy = ty[0];
		for (int i = 1; i < 3; i++) begin
			if (tx[i] < bminx) bminx = tx[i];
			if (tx[i] > bmaxx) bmaxx = tx[i];
			if (ty[i] < bminy) bminy = ty[i];
			if (ty[i] > bmaxy) bmaxy = ty[i];
		end
		if (bminx < 0) bminx = '0;
		if (bminy < 0) bminy = '0;
		if (bmaxx > 14'(FB_WIDTH)) bmaxx = 14'(FB_WIDTH);
		if (bmaxy > 14'(FB_HEIGHT)) bmaxy = 14'(FB_HEIGHT);
	end

	// shared multiplier operands: winding product pair, then one pair per edge at box corner
	logic [1:0]           mei;
	logic signed [PW-1:0] ptx, pty;
	logic signed [DW-1:0] opa, opb;
	logic signed [2*DW-1:0] prod;
	always_comb begin
		if (mul_k_q < 4'd2) begin
			mei = 2'd0;
			ptx = sx[2];
			pty = sy[2];
		end else begin
			mei = 2'((mul_k_q - 4'd2) >> 1);
			ptx = PW'(minx_q) <<< (FRAC_BITS + 2);
			pty = PW'(miny_q) <<< (FRAC_BITS + 2);
		end
		if (!mul_k_q[0]) begin
			opa = DW'(pty) - DW'(sy[mei]);
			opb = dx_q[mei];
		end else begin
			opa = DW'(ptx) - DW'(sx[mei]);
			opb = dy_q[mei];
		end
		prod = opa * opb;
	end

	// sub-sample coverage of the current pixel
	logic signed [EW-1:0] dxe, dye, oyd, oxd, smp;
	logic [3:0] cov;
	logic [2:0] ncov;
	always_comb begin
		cov = '1;
		for (int i = 0; i < 3; i++) begin
			dxe = EW'(dx_q[i]);
			dye = EW'(dy_q[i]);
			for (int k = 0; k < 4; k++) begin
				oyd = (k >= 2) ? (dxe + (dxe <<< 1)) : dxe;
				oxd = ((k % 2) == 1) ? (dye <<< 1) : dye;
				smp = ecur_q[i] + ((oyd - oxd) <<< FRAC_BITS);
				if (smp[EW-1]) cov[k] = 1'b0;
			end
		end
		ncov = 3'(cov[0]) + 3'(cov[1]) + 3'(cov[2]) + 3'(cov[3]);
	end

	logic signed [EW-1:0] stepx [3];
	logic signed [EW-1:0] stepy [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			stepx[i] = EW'(dy_q[i]) <<< (FRAC_BITS + 2);
			stepy[i] = EW'(dx_q[i]) <<< (FRAC_BITS + 2);
		end
	end

	logic in_range, accept, wind_pos, box_empty, row_end, walk_end;
	logic [AW-1:0] req_addr, walk_addr;
	assign accept    = start && (state_q == ST_IDLE);
	assign in_range  = (int'(pixel_x) < FB_WIDTH) && (int'(pixel_y) < FB_HEIGHT);
	assign req_addr  = AW'(int'(pixel_y) * FB_WIDTH + int'(pixel_x));
	assign walk_addr = AW'(int'(y_q) * FB_WIDTH + int'(x_q));
	assign wind_pos  = !wind_q[EW-1] && (wind_q != '0);
	assign box_empty = (minx_q >= maxx_q) || (miny_q >= maxy_q);
	assign row_end   = (x_q + 14'sd1) >= maxx_q;
	assign walk_end  = row_end && ((y_q + 14'sd1) >= maxy_q);

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_ADDR) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					priority if (req_type == REQ_DRAW) state_d = ST_SETUP;
					else if (req_type == REQ_READ && in_range) state_d = ST_PIX;
					else state_d = ST_DONE;
				end
			end
			ST_SETUP: state_d = ST_MUL;
			ST_MUL: begin
				if (mul_k_q == 4'd8) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				priority if (!wind_pos || box_empty) state_d = ST_DONE;
				else state_d = ST_WALK;
			end
			ST_WALK: begin
				if (walk_end) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_DONE;
			ST_PIX:   state_d = ST_DONE;
			ST_DONE: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			pv_q     <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			pv_q     <= (state_q == ST_MUL) && (mul_k_q < 4'd8);
			valid_s1 <= (state_q == ST_WALK) && (ncov != 3'd0);
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pv_q) begin
			if (tag_q < 3'd2) begin
				wind_q <= tag_q[0] ? wind_q - EW'(prod_q) : EW'(prod_q);
			end else begin
				erow_q[2'((tag_q - 3'd2) >> 1)] <= tag_q[0] ?
					erow_q[2'((tag_q - 3'd2) >> 1)] - EW'(prod_q) : EW'(prod_q);
			end
		end
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					vx_q[0]     <= vert0_x;
					vy_q[0]     <= vert0_y;
					vx_q[1]     <= vert1_x;
					vy_q[1]     <= vert1_y;
					vx_q[2]     <= vert2_x;
					vy_q[2]     <= vert2_y;
					color_q     <= draw_color;
					res_color_q <= '0;
					cnt_q       <= '0;
					front_q     <= 1'b0;
					mul_k_q     <= '0;
				end
			end
			ST_SETUP: begin
				for (int i = 0; i < 3; i++) begin
					dx_q[i] <= DW'(sx[(i + 1) % 3]) - DW'(sx[i]);
					dy_q[i] <= DW'(sy[(i + 1) % 3]) - DW'(sy[i]);
				end
				minx_q <= bminx;
				maxx_q <= bmaxx;
				miny_q <= bminy;
				maxy_q <= bmaxy;
			end
			ST_MUL: begin
				if (mul_k_q < 4'd8) begin
					prod_q  <= prod;
					tag_q   <= mul_k_q[2:0];
					mul_k_q <= mul_k_q + 4'd1;
				end
			end
			ST_CHECK: begin
				front_q <= wind_pos;
				x_q     <= minx_q;
				y_q     <= miny_q;
				for (int i = 0; i < 3; i++) ecur_q[i] <= erow_q[i];
			end
			ST_WALK: begin
				addr_s1 <= walk_addr;
				n_s1    <= ncov;
				if (ncov != 3'd0 && cnt_q != COUNT_MAX) cnt_q <= cnt_q + 13'd1;
				if (!row_end) begin
					x_q <= x_q + 14'sd1;
					for (int i = 0; i < 3; i++) ecur_q[i] <= ecur_q[i] - stepx[i];
				end else begin
					x_q <= minx_q;
					y_q <= y_q + 14'sd1;
					for (int i = 0; i < 3; i++) begin
						erow_q[i] <= erow_q[i] + stepy[i];
						ecur_q[i] <= erow_q[i] + stepy[i];
					end
				end
			end
			ST_PIX: res_color_q <= rdata;
			ST_CLEAR, ST_DRAIN, ST_DONE: ;
			default: ;
		endcase
	end

	// frame store ports: clearing pass, pixel requests, walk read and blended write-back
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [23:0]   ram_wdata;
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		priority if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
		end else if (valid_s1) begin
			ram_we    = 1'b1;
			ram_waddr = addr_s1;
			ram_wdata = blend(rdata, color_q, n_s1);
		end else if (accept && req_type == REQ_WRITE && in_range) begin
			ram_we    = 1'b1;
			ram_waddr = req_addr;
			ram_wdata = draw_color;
		end
		ram_re    = 1'b0;
		ram_raddr = walk_addr;
		priority if (state_q == ST_WALK) begin
			ram_re = ncov != 3'd0;
		end else if (accept && req_type == REQ_READ && in_range) begin
			ram_re    = 1'b1;
			ram_raddr = req_addr;
		end
	end

	trs_ram #(
		.WIDTH(24),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	assign pixel_color    = res_color_q;
	assign pixels_changed = cnt_q;
	assign front_facing   = front_q;

endmodule

FILE: hw/rtl/trs_checker.sv
// port-level checks for the supersampling triangle rasterizer, bound to the top level
// depends on triangle_raster_supersample
`timescale 1ns / 1ps

module trs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [23:0] pixel_color,
	input logic [12:0] pixels_changed,
	input logic        front_facing
);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result word while idle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted word did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");

	a_draw_no_color: assert property (@(posedge clk) disable iff (!arst_n)
		(done && front_facing) |-> (pixel_color == 24'd0))
		else $error("draw result carries a color");

	a_back_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !front_facing) |-> (pixels_changed == 13'd0))
		else $error("count without a drawn triangle");

endmodule

bind triangle_raster_supersample trs_checker u_trs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.pixel_color   (pixel_color),
	.pixels_changed(pixels_changed),
	.front_facing  (front_facing)
);
